FILE: sv/sbp_pkg.sv
// ----------------------------------------------------------------------------
// sbp_pkg
// shared widths, fixed-point constants and register indexes of the spectrum
// bin to pixel resampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbp_pkg;

   // fixed-point format and limits
   localparam int FRAC_BITS   = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_PPB     = 32;
   localparam int MAX_RESULTS = MAX_PPB + 1;
   localparam int N_W         = $clog2(MAX_RESULTS + 1);

   // field and state widths
   localparam int VAL_W   = 16;
   localparam int IDX_W   = 12;
   localparam int BIN_W   = 17;
   localparam int PIX_W   = 13;
   localparam int SR_W    = 18;
   localparam int FREQ_W  = 17;
   localparam int FFT_W   = 17;
   localparam int Q_W     = 32;
   localparam int SUM_W   = 48;
   localparam int FRAC1_W = FRAC_BITS + 1;

   // shared divider operand widths
   localparam int DIV_N_W = 48;
   localparam int DIV_D_W = 32;
   localparam int DIV_C_W = $clog2(DIV_N_W);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [Q_W-1:0]   ONE_Q      = Q_W'(1) << FRAC_BITS;
   localparam logic [Q_W-1:0]   MAX_PPB_Q  = Q_W'(MAX_PPB) << FRAC_BITS;
   localparam logic [BIN_W-1:0] BIN_MAX    = {BIN_W{1'b1}};
   localparam logic [DIV_N_W-1:0] SAMPLE_MAX = DIV_N_W'({SAMPLE_BITS{1'b1}});

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_RATE = 3'd0,
      CSR_FFT_SIZE    = 3'd1,
      CSR_LOW_FREQ    = 3'd2,
      CSR_HIGH_FREQ   = 3'd3,
      CSR_PIXEL_COUNT = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

FILE: sv/sbp_if.sv
// ----------------------------------------------------------------------------
// sbp_if
// valid/ready channels for bins in and pixels out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbp_req_if import sbp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] bin_value;
   logic             frame_start;

   modport source (output valid, bin_value, frame_start, input ready);
   modport sink   (input valid, bin_value, frame_start, output ready);
endinterface

interface sbp_rsp_if import sbp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] pixel_value;
   logic [IDX_W-1:0] pixel_index;
   logic             last_of_run;
   logic             ratio_error;

   modport source (output valid, pixel_value, pixel_index, last_of_run, ratio_error,
                   input ready);
   modport sink   (input valid, pixel_value, pixel_index, last_of_run, ratio_error,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/spectrum_bin_to_pixel_resampler.sv
// ----------------------------------------------------------------------------
// spectrum_bin_to_pixel_resampler
// area-weighted rebinning of FFT bin magnitudes onto a pixel axis
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  req_bus  | in        | bin_value, frame_start
//  rsp_bus  | out       | pixel_value, pixel_index, last_of_run, ratio_error
//  csr_*    | in        | csr_wr_en, csr_index, csr_wr_data (write only)
//
//  all divisions run on one shared 48-step divider, one at a time;
//  a frame start bin costs up to four divisions before its pixels
//  a bin that only accumulates adds to the sum, a pass-through bin is copied
//  out, a bin that closes a pixel waits on a division and then on each extra pixel
//  synchronous reset clears control state; there is no clearing pass
//  results sit in an output register; the sequencer waits while it is full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spectrum_bin_to_pixel_resampler import sbp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   sbp_req_if.sink                    req_bus,
   sbp_rsp_if.source                  rsp_bus,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FBIN, ST_FBIN_WAIT, ST_LBIN, ST_LBIN_WAIT, ST_SPAN,
      ST_BPP_WAIT, ST_PPB, ST_PPB_WAIT, ST_CHECK, ST_ERR_OUT, ST_PROC,
      ST_MORE_DIV, ST_FEW_DIV, ST_DIV_WAIT, ST_DIV_EMIT
   } state_type;

   // saturation helpers
   function automatic logic [VAL_W-1:0] sat_val(input logic [DIV_N_W-1:0] q);
      logic [DIV_N_W-1:0] s;
      s = (q > SAMPLE_MAX) ? SAMPLE_MAX : q;
      sat_val = (s > DIV_N_W'({VAL_W{1'b1}})) ? {VAL_W{1'b1}} : s[VAL_W-1:0];
   endfunction

   function automatic logic [BIN_W-1:0] sat_bin(input logic [DIV_N_W-1:0] q);
      sat_bin = (q > DIV_N_W'(BIN_MAX)) ? BIN_MAX : q[BIN_W-1:0];
   endfunction

   function automatic logic [Q_W-1:0] sat_q(input logic [DIV_N_W-1:0] q);
      sat_q = (q > DIV_N_W'({Q_W{1'b1}})) ? {Q_W{1'b1}} : q[Q_W-1:0];
   endfunction

   // configuration registers
   logic [SR_W-1:0]   sr_ff;
   logic [FFT_W-1:0]  fft_ff;
   logic [FREQ_W-1:0] lo_ff, hi_ff;
   logic [PIX_W-1:0]  pcount_ff;

   // sequencer and frame state
   state_type          state_ff, state_in;
   logic               pass_ff, pass_in;
   logic [VAL_W-1:0]   v_ff, v_in;
   logic               err_ff, err_in;
   logic               fv_ff, fv_in;
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [PIX_W-1:0]   pc_ff, pc_in;
   logic [BIN_W-1:0]   first_ff, first_in, last_ff, last_in, span_ff, span_in;
   logic [Q_W-1:0]     bpp_ff, bpp_in, ppb_ff, ppb_in, rs_ff, rs_in;
   logic [FRAC1_W-1:0] fu_ff, fu_in, rt_ff, rt_in;
   logic [SUM_W-1:0]   ws_ff, ws_in;
   logic [N_W-1:0]     n_ff, n_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [VAL_W-1:0]   out_value_ff, out_value_in;
   logic [IDX_W-1:0]   out_index_ff, out_index_in;
   logic               out_last_ff, out_last_in;
   logic               out_err_ff, out_err_in;

   // shared divider hookup
   logic               div_start, div_busy, div_done;
   logic [DIV_N_W-1:0] div_dividend, div_quotient;
   logic [DIV_D_W-1:0] div_divisor;

   // combinational helpers
   logic               slot_free, out_load, accept;
   logic [BIN_W-1:0]   span_w;
   logic [FRAC1_W-1:0] bpp_lo;
   logic [FRAC1_W:0]   step1, step2, one_w;
   logic [SUM_W:0]     acc_w;
   logic               few_mode, more_after;

   sbp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign slot_free = !out_valid_ff || rsp_bus.ready;
   assign accept    = req_bus.valid && req_bus.ready;

   // sequencer
   always_comb begin
      span_w     = (last_ff > first_ff) ? BIN_W'(last_ff - first_ff) : '0;
      bpp_lo     = bpp_ff[FRAC1_W-1:0];
      one_w      = (FRAC1_W+1)'(ONE_Q);
      step1      = (FRAC1_W+1)'(rt_ff) + (FRAC1_W+1)'(bpp_lo);
      step2      = step1 + (FRAC1_W+1)'(bpp_lo);
      few_mode   = bpp_ff < ONE_Q;
      more_after = few_mode && ((PIX_W+1)'(pc_ff) + 1'b1 < (PIX_W+1)'(pcount_ff))
                   && (step1 < one_w);
      acc_w      = '0;

      state_in = state_ff;
      pass_in  = pass_ff;
      v_in     = v_ff;
      err_in   = err_ff;
      fv_in    = fv_ff;
      bin_in   = bin_ff;
      pc_in    = pc_ff;
      first_in = first_ff;
      last_in  = last_ff;
      span_in  = span_ff;
      bpp_in   = bpp_ff;
      ppb_in   = ppb_ff;
      rs_in    = rs_ff;
      fu_in    = fu_ff;
      rt_in    = rt_ff;
      ws_in    = ws_ff;
      n_in     = n_ff;

      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      out_load     = 1'b0;
      out_value_in = out_value_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pass_ff) begin
               // one bin per pixel: pass through
               if (slot_free) begin
                  out_load     = 1'b1;
                  out_value_in = v_ff;
                  out_index_in = pc_ff[IDX_W-1:0];
                  out_last_in  = 1'b1;
                  out_err_in   = 1'b0;
                  pc_in        = pc_ff + 1'b1;
                  pass_in      = 1'b0;
               end
            end else if (accept) begin
               v_in     = req_bus.bin_value;
               err_in   = 1'b0;
               state_in = req_bus.frame_start ? ST_FBIN : ST_PROC;
            end
         end

         // bin limits from the frequency registers
         ST_FBIN: begin
            if (sr_ff == '0) begin
               first_in = '0;
               state_in = ST_LBIN;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_N_W'((FREQ_W+FFT_W)'(lo_ff) * (FREQ_W+FFT_W)'(fft_ff));
               div_divisor  = DIV_D_W'(sr_ff);
               state_in     = ST_FBIN_WAIT;
            end
         end
         ST_FBIN_WAIT: begin
            if (div_done) begin
               first_in = sat_bin(div_quotient);
               state_in = ST_LBIN;
            end
         end
         ST_LBIN: begin
            if (sr_ff == '0) begin
               last_in  = '0;
               state_in = ST_SPAN;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_N_W'((FREQ_W+FFT_W)'(hi_ff) * (FREQ_W+FFT_W)'(fft_ff));
               div_divisor  = DIV_D_W'(sr_ff);
               state_in     = ST_LBIN_WAIT;
            end
         end
         ST_LBIN_WAIT: begin
            if (div_done) begin
               last_in  = sat_bin(div_quotient);
               state_in = ST_SPAN;
            end
         end

         // bins per pixel and pixels per bin
         ST_SPAN: begin
            span_in = span_w;
            if (span_w == '0 || pcount_ff == '0) begin
               err_in   = 1'b1;
               bpp_in   = '0;
               ppb_in   = '0;
               state_in = ST_CHECK;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_N_W'(span_w) << FRAC_BITS;
               div_divisor  = DIV_D_W'(pcount_ff);
               state_in     = ST_BPP_WAIT;
            end
         end
         ST_BPP_WAIT: begin
            if (div_done) begin
               bpp_in   = sat_q(div_quotient);
               state_in = ST_PPB;
            end
         end
         ST_PPB: begin
            div_start    = 1'b1;
            div_dividend = DIV_N_W'(pcount_ff) << FRAC_BITS;
            div_divisor  = DIV_D_W'(span_ff);
            state_in     = ST_PPB_WAIT;
         end
         ST_PPB_WAIT: begin
            if (div_done) begin
               ppb_in   = sat_q(div_quotient);
               state_in = ST_CHECK;
            end
         end

         // ratio check and frame init
         ST_CHECK: begin
            bin_in = '0;
            pc_in  = '0;
            rs_in  = bpp_ff;
            fu_in  = '0;
            ws_in  = '0;
            if (err_ff || bpp_ff == '0 || ppb_ff > MAX_PPB_Q
                || (DIV_N_W'(bpp_ff) * DIV_N_W'(MAX_PPB)) < DIV_N_W'(ONE_Q)) begin
               fv_in    = 1'b0;
               state_in = ST_ERR_OUT;
            end else begin
               fv_in    = 1'b1;
               state_in = ST_PROC;
            end
         end
         ST_ERR_OUT: begin
            if (slot_free) begin
               out_load     = 1'b1;
               out_value_in = '0;
               out_index_in = '0;
               out_last_in  = 1'b1;
               out_err_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         // one bin of a valid frame
         ST_PROC: begin
            state_in = ST_IDLE;
            if (fv_ff) begin
               bin_in = (bin_ff != BIN_MAX) ? bin_ff + 1'b1 : bin_ff;
               if (bin_ff >= first_ff && bin_ff <= last_ff && pc_ff < pcount_ff) begin
                  if (bpp_ff > ONE_Q) begin
                     if (rs_ff > ONE_Q) begin
                        acc_w = (SUM_W+1)'(ws_ff) + ((SUM_W+1)'(v_ff) << FRAC_BITS);
                        ws_in = acc_w[SUM_W] ? {SUM_W{1'b1}} : acc_w[SUM_W-1:0];
                        rs_in = rs_ff - ONE_Q;
                     end else begin
                        acc_w    = (SUM_W+1)'(ws_ff) + (SUM_W+1)'(v_ff * rs_ff);
                        ws_in    = acc_w[SUM_W] ? {SUM_W{1'b1}} : acc_w[SUM_W-1:0];
                        state_in = ST_MORE_DIV;
                     end
                  end else if (bpp_ff == ONE_Q) begin
                     pass_in = 1'b1;
                  end else begin
                     rt_in    = fu_ff;
                     n_in     = '0;
                     state_in = (bin_ff > first_ff) ? ST_FEW_DIV : ST_DIV_EMIT;
                  end
               end
            end
         end

         // pixel closes: mean over the covered span
         ST_MORE_DIV: begin
            div_start    = 1'b1;
            div_dividend = DIV_N_W'(ws_ff);
            div_divisor  = bpp_ff;
            ws_in        = SUM_W'((VAL_W+FRAC1_W)'(v_ff)
                                  * (VAL_W+FRAC1_W)'(ONE_Q - rs_ff));
            rs_in        = bpp_ff - (ONE_Q - rs_ff);
            state_in     = ST_DIV_WAIT;
         end
         // straddling pixel: blend of the previous and this bin
         ST_FEW_DIV: begin
            div_start    = 1'b1;
            div_dividend = DIV_N_W'(ws_ff + SUM_W'((VAL_W+FRAC1_W)'(v_ff)
                                                   * (VAL_W+FRAC1_W)'(rt_ff)));
            div_divisor  = bpp_ff;
            state_in     = ST_DIV_WAIT;
         end
         // quotient holds once the divider is idle, so a full slot just waits
         ST_DIV_WAIT: begin
            if (!div_busy && slot_free) begin
               out_load     = 1'b1;
               out_value_in = sat_val(div_quotient);
               out_index_in = pc_ff[IDX_W-1:0];
               out_last_in  = !more_after;
               out_err_in   = 1'b0;
               pc_in        = pc_ff + 1'b1;
               n_in         = n_ff + 1'b1;
               state_in     = few_mode ? ST_DIV_EMIT : ST_IDLE;
            end
         end

         // pixels inside one bin, then carry the remainder
         ST_DIV_EMIT: begin
            if (pc_ff < pcount_ff && n_ff < N_W'(MAX_RESULTS) && step1 < one_w) begin
               if (slot_free) begin
                  out_load     = 1'b1;
                  out_value_in = v_ff;
                  out_index_in = pc_ff[IDX_W-1:0];
                  out_last_in  = !(((PIX_W+1)'(pc_ff) + 1'b1 < (PIX_W+1)'(pcount_ff))
                                   && (n_ff + 1'b1 < N_W'(MAX_RESULTS))
                                   && (step2 < one_w));
                  out_err_in   = 1'b0;
                  pc_in        = pc_ff + 1'b1;
                  n_in         = n_ff + 1'b1;
                  rt_in        = step1[FRAC1_W-1:0];
               end
            end else begin
               ws_in    = SUM_W'((VAL_W+FRAC1_W)'(v_ff)
                                 * (VAL_W+FRAC1_W)'(one_w - (FRAC1_W+1)'(rt_ff)));
               fu_in    = (step1 >= one_w) ? FRAC1_W'(step1 - one_w) : '0;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // state, configuration and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         err_ff       <= 1'b0;
         fv_ff        <= 1'b0;
         bin_ff       <= '0;
         pc_ff        <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         span_ff      <= '0;
         bpp_ff       <= '0;
         ppb_ff       <= '0;
         rs_ff        <= '0;
         fu_ff        <= '0;
         rt_ff        <= '0;
         ws_ff        <= '0;
         n_ff         <= '0;
         out_valid_ff <= 1'b0;
         sr_ff        <= SR_W'(44100);
         fft_ff       <= FFT_W'(2048);
         lo_ff        <= '0;
         hi_ff        <= FREQ_W'(22050);
         pcount_ff    <= PIX_W'(512);
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         err_ff       <= err_in;
         fv_ff        <= fv_in;
         bin_ff       <= bin_in;
         pc_ff        <= pc_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         span_ff      <= span_in;
         bpp_ff       <= bpp_in;
         ppb_ff       <= ppb_in;
         rs_ff        <= rs_in;
         fu_ff        <= fu_in;
         rt_ff        <= rt_in;
         ws_ff        <= ws_in;
         n_ff         <= n_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SAMPLE_RATE: sr_ff     <= csr_wr_data[SR_W-1:0];
               CSR_FFT_SIZE:    fft_ff    <= csr_wr_data[FFT_W-1:0];
               CSR_LOW_FREQ:    lo_ff     <= csr_wr_data[FREQ_W-1:0];
               CSR_HIGH_FREQ:   hi_ff     <= csr_wr_data[FREQ_W-1:0];
               CSR_PIXEL_COUNT: pcount_ff <= csr_wr_data[PIX_W-1:0];
               default: ;
            endcase
         end
      end
      v_ff         <= v_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
      out_err_ff   <= out_err_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE) && !pass_ff;
   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.pixel_value = out_value_ff;
   assign rsp_bus.pixel_index = out_index_ff;
   assign rsp_bus.last_of_run = out_last_ff;
   assign rsp_bus.ratio_error = out_err_ff;

   // checks
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ratio_error |->
         rsp_bus.last_of_run && rsp_bus.pixel_value == '0 && rsp_bus.pixel_index == '0)
      else $error("error transaction with a pixel payload");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_bus.ready) else $error("new bin taken while one is in work");
   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> slot_free) else $error("output register overwritten");

endmodule

`default_nettype wire

FILE: sv/sbp_div.sv
// ----------------------------------------------------------------------------
// sbp_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbp_div import sbp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] dividend,
   input  wire logic [DIV_D_W-1:0] divisor,
   output logic                    busy,
   output logic                    done,
   output logic [DIV_N_W-1:0]      quotient
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_C_W-1:0] count_ff, count_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] dsr_ff, dsr_in;
   logic [DIV_N_W-1:0] quo_ff, quo_in;
   logic [DIV_D_W:0]   rem_sh;
   logic               ge;

   // one shift-and-subtract step
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIV_N_W-1]};
      ge       = rem_sh >= {1'b0, dsr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      if (start && !busy_ff) begin
         busy_in  = 1'b1;
         count_in = DIV_C_W'(DIV_N_W - 1);
         rem_in   = '0;
         dsr_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = ge ? DIV_D_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[DIV_D_W-1:0];
         quo_in   = {quo_ff[DIV_N_W-2:0], ge};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   // checks
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without a running division");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      busy_ff && count_ff != '0 |=> busy_ff) else $error("divider stopped early");

endmodule

`default_nettype wire
